// File: rtl/labeled_nearest_point_matcher_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the labeled nearest point matcher
// Shorthands for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef LABELED_NEAREST_POINT_MATCHER_TOP_ASSERT_SVH
`define LABELED_NEAREST_POINT_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, checked while reset is released.
`define LNPM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lnpm assertion failed");

// Next-cycle implication, checked while reset is released.
`define LNPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lnpm assertion failed");

`endif

// File: rtl/lnpm_pkg.sv
// ---------------------------------------------------------------------------
// lnpm_pkg
// Sizes, the gate reset value and the search token type of the point matcher.
// ---------------------------------------------------------------------------
package lnpm_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int COORD_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int LABEL_W     = 2;
    localparam int REF_IDX_W   = 6;
    localparam int QIDX_W      = 6;
    localparam int DIST_W      = 32;
    localparam int SQ_W        = 2 * COORD_BITS;
    localparam int SUM_W       = (SQ_W + 1 > DIST_W + 1) ? SQ_W + 1 : DIST_W + 1;

    localparam logic [DIST_W-1:0] GATE_RESET = 32'd671089;

    // The search token that walks the cell row, carrying the best match so far.
    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [LABEL_W-1:0]    label;
        logic [QIDX_W-1:0]     qidx;
        logic                  hit;
        logic [DIST_W-1:0]     best;
        logic [IDX_W-1:0]      bidx;
    } t_tok;

endpackage

// File: rtl/lnpm_if.sv
// ---------------------------------------------------------------------------
// lnpm channel interfaces
// Valid/ready channels for point beats in and match beats out.
// ---------------------------------------------------------------------------
interface lnpm_in_if
    import lnpm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic                  start_set;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [LABEL_W-1:0]    class_label;

    modport source (output valid, action, start_set, pos_x, pos_y, class_label,
                    input ready);
    modport sink   (input valid, action, start_set, pos_x, pos_y, class_label,
                    output ready);
endinterface

interface lnpm_out_if
    import lnpm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [REF_IDX_W-1:0] ref_index;
    logic [QIDX_W-1:0]    query_index;
    logic [DIST_W-1:0]    dist_sq;

    modport source (output valid, found, ref_index, query_index, dist_sq,
                    input ready);
    modport sink   (input valid, found, ref_index, query_index, dist_sq,
                    output ready);
endinterface

// File: rtl/lnpm_cell.sv
// ---------------------------------------------------------------------------
// lnpm_cell
// One reference point slot: holds a point and updates the passing token.
// ---------------------------------------------------------------------------
module lnpm_cell
    import lnpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_wr_en,
    input  logic [COORD_BITS-1:0] i_wr_x,
    input  logic [COORD_BITS-1:0] i_wr_y,
    input  logic [LABEL_W-1:0]    i_wr_label,
    input  logic                  i_active,
    input  logic [IDX_W-1:0]      i_index,
    input  t_tok                  i_tok,
    output t_tok                  o_tok
);

    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [LABEL_W-1:0]    r_plabel;

    t_tok                  r_a_tok;
    logic                  r_a_ok;
    logic [SQ_W-1:0]       r_sq_x;
    logic [SQ_W-1:0]       r_sq_y;
    t_tok                  r_b_tok;

    logic [COORD_BITS:0]   w_diff_x;
    logic [COORD_BITS:0]   w_diff_y;
    logic [COORD_BITS-1:0] w_abs_x;
    logic [COORD_BITS-1:0] w_abs_y;
    logic [SUM_W-1:0]      w_dist;
    logic                  w_better;
    t_tok                  n_b_tok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_px     <= i_wr_x;
            r_py     <= i_wr_y;
            r_plabel <= i_wr_label;
        end
    end

    // Signed difference in one extra bit; its magnitude always fits COORD_BITS.
    always_comb begin
        w_diff_x = {i_tok.x[COORD_BITS-1], i_tok.x} - {r_px[COORD_BITS-1], r_px};
        w_diff_y = {i_tok.y[COORD_BITS-1], i_tok.y} - {r_py[COORD_BITS-1], r_py};
        w_abs_x  = w_diff_x[COORD_BITS] ? COORD_BITS'(-w_diff_x)
                                        : w_diff_x[COORD_BITS-1:0];
        w_abs_y  = w_diff_y[COORD_BITS] ? COORD_BITS'(-w_diff_y)
                                        : w_diff_y[COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_a_tok.valid <= i_tok.valid;
        end
        if (i_adv) begin
            r_a_tok.x     <= i_tok.x;
            r_a_tok.y     <= i_tok.y;
            r_a_tok.label <= i_tok.label;
            r_a_tok.qidx  <= i_tok.qidx;
            r_a_tok.hit   <= i_tok.hit;
            r_a_tok.best  <= i_tok.best;
            r_a_tok.bidx  <= i_tok.bidx;
            r_a_ok        <= i_active && (i_tok.label == r_plabel);
            r_sq_x        <= SQ_W'(w_abs_x) * SQ_W'(w_abs_x);
            r_sq_y        <= SQ_W'(w_abs_y) * SQ_W'(w_abs_y);
        end
    end

    // Strict compare keeps the earliest index on equal distances.
    always_comb begin
        w_dist   = SUM_W'(r_sq_x) + SUM_W'(r_sq_y);
        w_better = r_a_ok && (w_dist < SUM_W'(r_a_tok.best));
        n_b_tok  = r_a_tok;
        if (w_better) begin
            n_b_tok.hit  = 1'b1;
            n_b_tok.best = DIST_W'(w_dist);
            n_b_tok.bidx = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_b_tok.valid <= n_b_tok.valid;
        end
        if (i_adv) begin
            r_b_tok.x     <= n_b_tok.x;
            r_b_tok.y     <= n_b_tok.y;
            r_b_tok.label <= n_b_tok.label;
            r_b_tok.qidx  <= n_b_tok.qidx;
            r_b_tok.hit   <= n_b_tok.hit;
            r_b_tok.best  <= n_b_tok.best;
            r_b_tok.bidx  <= n_b_tok.bidx;
        end
    end

    assign o_tok = r_b_tok;

endmodule

// File: rtl/labeled_nearest_point_matcher_top.sv
// ---------------------------------------------------------------------------
// labeled_nearest_point_matcher_top
// Gated nearest neighbor search over a row of labeled reference point cells.
// ---------------------------------------------------------------------------
// Usage:
// Input beats on i_in either store a reference point (action 0) or query
// one (action 1). A store with start_set clears the reference set and the
// query counter before writing its point. Stores stream at one beat per
// cycle while no query is in flight; a store into a full set is dropped.
// A query beat launches a search token through a row of MAX_POINTS cells,
// each cell passing it through a square stage, then a compare stage. The
// result is registered into o_out when the token leaves the last cell;
// i_in is not ready from the query beat until that load, so a new query
// enters only after the last one's result has left the row.
// Each query gives one o_out beat: found, ref_index, query_index, dist_sq.
// If o_out is stalled, the next query can still enter; its token parks at
// the end of the row until the waiting result is taken.
// The gate register is written through i_cfg_we and i_cfg_wdata.
// Reset clears the point count, the query counter, the pipeline valid bits
// and loads the gate with its default of 0.2 m squared.
// ---------------------------------------------------------------------------
module labeled_nearest_point_matcher_top
    import lnpm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    lnpm_in_if.sink            i_in,
    lnpm_out_if.source         o_out,
    input  logic               i_cfg_we,
    input  logic [DIST_W-1:0]  i_cfg_wdata
);

`include "labeled_nearest_point_matcher_top_assert.svh"

    logic [DIST_W-1:0]    r_gate;
    logic [CNT_W-1:0]     r_ref_count;
    logic [QIDX_W-1:0]    r_qcount;
    logic                 r_busy;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [REF_IDX_W-1:0] r_out_ref_index;
    logic [QIDX_W-1:0]    r_out_query_index;
    logic [DIST_W-1:0]    r_out_dist_sq;

    logic                 w_accept;
    logic                 w_store;
    logic                 w_query;
    logic [CNT_W-1:0]     w_base_count;
    logic                 w_wr_ok;
    logic                 w_adv;
    logic                 w_load;
    t_tok                 w_chain [MAX_POINTS+1];
    logic [MAX_POINTS-1:0] w_tok_valid;

    assign i_in.ready   = !r_busy;
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_store      = w_accept && !i_in.action;
    assign w_query      = w_accept && i_in.action;
    assign w_base_count = i_in.start_set ? '0 : r_ref_count;
    assign w_wr_ok      = w_store && (w_base_count < CNT_W'(MAX_POINTS));

    // The row freezes only while a finished token waits for the output register.
    assign w_adv  = !(w_chain[MAX_POINTS].valid && r_out_valid && !o_out.ready);
    assign w_load = w_chain[MAX_POINTS].valid && w_adv;

    always_comb begin
        w_chain[0].valid = w_query;
        w_chain[0].x     = i_in.pos_x;
        w_chain[0].y     = i_in.pos_y;
        w_chain[0].label = i_in.class_label;
        w_chain[0].qidx  = r_qcount;
        w_chain[0].hit   = 1'b0;
        w_chain[0].best  = r_gate;
        w_chain[0].bidx  = '0;
    end

    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        lnpm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_wr_en    (w_wr_ok && (w_base_count[IDX_W-1:0] == IDX_W'(k))),
            .i_wr_x     (i_in.pos_x),
            .i_wr_y     (i_in.pos_y),
            .i_wr_label (i_in.class_label),
            .i_active   (CNT_W'(k) < r_ref_count),
            .i_index    (IDX_W'(k)),
            .i_tok      (w_chain[k]),
            .o_tok      (w_chain[k+1])
        );
        assign w_tok_valid[k] = w_chain[k+1].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= GATE_RESET;
        end else if (i_cfg_we) begin
            r_gate <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_count <= '0;
            r_qcount    <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_store) begin
                r_ref_count <= w_wr_ok ? w_base_count + CNT_W'(1) : w_base_count;
                if (i_in.start_set) begin
                    r_qcount <= '0;
                end
            end else if (w_query) begin
                r_qcount <= r_qcount + QIDX_W'(1);
            end

            if (w_query) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_found       <= w_chain[MAX_POINTS].hit;
            r_out_ref_index   <= w_chain[MAX_POINTS].hit
                                 ? REF_IDX_W'(w_chain[MAX_POINTS].bidx) : '0;
            r_out_query_index <= w_chain[MAX_POINTS].qidx;
            r_out_dist_sq     <= w_chain[MAX_POINTS].hit ? w_chain[MAX_POINTS].best : '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.ref_index   = r_out_ref_index;
    assign o_out.query_index = r_out_query_index;
    assign o_out.dist_sq     = r_out_dist_sq;

    // At most one search token is ever in the row.
    `LNPM_ASSERT_NOW(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(w_tok_valid))
    // With no query in flight the row holds no token.
    `LNPM_ASSERT_NOW(a_idle_empty, i_clk, i_rst_n, !r_busy, w_tok_valid == '0)
    // A reported match always lies strictly under the gate.
    `LNPM_ASSERT_NOW(a_under_gate, i_clk, i_rst_n, r_out_valid && r_out_found,
                     r_out_dist_sq < r_gate)
    // A miss reports zero index and zero distance.
    `LNPM_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_out_found,
                     r_out_ref_index == '0 && r_out_dist_sq == '0)
    // A query beat makes the block busy on the next cycle.
    `LNPM_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_query, r_busy)

endmodule

// File: bench/labeled_nearest_point_matcher_top_test.sv
// ---------------------------------------------------------------------------
// labeled_nearest_point_matcher_top_test
// Self-checking bench for the labeled nearest point matcher. Point beats are
// queued by a stimulus process and sent by a clocked driver. A matcher model
// runs inside the bench on every accepted beat. A clocked monitor compares
// each match beat with the oldest predicted match. The gate register is
// written between phases, while the block is idle. Both channels stall at
// random but in the last phase; a long match hold-off backs up the point side.
// ---------------------------------------------------------------------------
module labeled_nearest_point_matcher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lnpm_pkg::*;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam int SETTLE_CYCLES     = 2 * MAX_POINTS + 8;
    localparam int HOLD_CYCLES       = 1500;
    localparam int HOLD_AFTER_RESULT = 60;
    localparam int PHASE_ITEMS       = 215;
    localparam int PHASE_COUNT       = 6;
    localparam int RANDOM_GATE_PHASE = 2;

    typedef struct {
        logic                         action;
        logic                         start_set;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [LABEL_W-1:0]           label;
    } t_point_beat;

    typedef struct {
        logic                 found;
        logic [REF_IDX_W-1:0] ref_index;
        logic [QIDX_W-1:0]    query_index;
        logic [DIST_W-1:0]    dist_sq;
    } t_match;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we;
    logic [DIST_W-1:0] i_cfg_wdata;

    lnpm_in_if  point_if();
    lnpm_out_if match_if();

    t_point_beat pending_beats[$];
    t_match      expected_matches[$];

    // Mirror of the reference set, the query counter and the gate.
    logic signed [COORD_BITS-1:0] set_x     [MAX_POINTS];
    logic signed [COORD_BITS-1:0] set_y     [MAX_POINTS];
    logic [LABEL_W-1:0]           set_label [MAX_POINTS];
    int                           set_size;
    logic [QIDX_W-1:0]            query_count;
    logic [DIST_W-1:0]            gate_now;

    logic [DIST_W-1:0] gate_plan [PHASE_COUNT] =
        '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd4_000_000, GATE_RESET, 32'd500};
    int spread_plan [PHASE_COUNT] = '{300, 20000, 0, 1800, 700, 30};

    int stores_seen    = 0;
    int dropped_stores = 0;
    int queries_seen   = 0;
    int hits_seen      = 0;
    int wraps_seen     = 0;
    int error_count    = 0;
    int results_seen   = 0;
    int beats_queued   = 0;
    int gate_settings  = 0;
    bit idle_on        = 1'b1;

    labeled_nearest_point_matcher_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (point_if),
        .o_out       (match_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void update_matcher_model(input t_point_beat b);
        t_match m;
        longint best;
        longint d;
        int     dx;
        int     dy;
        if (b.action == ACT_STORE) begin
            stores_seen++;
            if (b.start_set) begin
                set_size    = 0;
                query_count = '0;
            end
            if (set_size < MAX_POINTS) begin
                set_x[set_size]     = b.x;
                set_y[set_size]     = b.y;
                set_label[set_size] = b.label;
                set_size++;
            end else begin
                dropped_stores++;
            end
        end else begin
            best        = {32'd0, gate_now};
            m.found     = 1'b0;
            m.ref_index = '0;
            m.dist_sq   = '0;
            // Strict compare keeps the earliest index among equal distances.
            for (int j = 0; j < set_size; j++) begin
                if (set_label[j] == b.label) begin
                    dx = int'(b.x) - int'(set_x[j]);
                    dy = int'(b.y) - int'(set_y[j]);
                    d  = longint'(dx) * dx + longint'(dy) * dy;
                    if (d < best) begin
                        best        = d;
                        m.found     = 1'b1;
                        m.ref_index = REF_IDX_W'(j);
                    end
                end
            end
            m.query_index = query_count;
            if (m.found) begin
                m.dist_sq = best[DIST_W-1:0];
                hits_seen++;
            end
            if (query_count == '1)
                wraps_seen++;
            query_count = query_count + QIDX_W'(1);
            queries_seen++;
            expected_matches.insert(expected_matches.size(), m);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Point driver: a beat stays on the bus until it is taken.
    int unsigned send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            point_if.valid       <= 1'b0;
            point_if.action      <= ACT_STORE;
            point_if.start_set   <= 1'b0;
            point_if.pos_x       <= '0;
            point_if.pos_y       <= '0;
            point_if.class_label <= '0;
            send_gap = 0;
        end else begin
            if (point_if.valid && point_if.ready)
                update_matcher_model(pending_beats.pop_front());
            if (!point_if.valid || point_if.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    point_if.valid <= 1'b0;
                end else if (idle_on && pending_beats.size() != 0 &&
                             $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 14);
                    point_if.valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    point_if.valid       <= 1'b1;
                    point_if.action      <= pending_beats[0].action;
                    point_if.start_set   <= pending_beats[0].start_set;
                    point_if.pos_x       <= pending_beats[0].x;
                    point_if.pos_y       <= pending_beats[0].y;
                    point_if.class_label <= pending_beats[0].label;
                end else begin
                    point_if.valid <= 1'b0;
                end
            end
        end
    end

    // Match-side ready, with one long hold-off once results are flowing.
    int unsigned take_gap;
    int unsigned hold_left;
    bit          held_once;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            match_if.ready <= 1'b0;
            take_gap  = 0;
            hold_left = 0;
            held_once = 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            match_if.ready <= 1'b0;
        end else if (!held_once && results_seen >= HOLD_AFTER_RESULT) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            match_if.ready <= 1'b0;
        end else if (take_gap != 0) begin
            take_gap--;
            match_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            take_gap = $urandom_range(0, 14);
            match_if.ready <= 1'b0;
        end else begin
            match_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : match_monitor
        t_match want;
        if (i_rst_n && match_if.valid && match_if.ready) begin
            results_seen <= results_seen + 1;
            if (expected_matches.size() == 0) begin
                error_count++;
                $display("%0t: match beat with none pending, expected none, actual %0d %0d %0d %0d",
                         $time, match_if.found, match_if.ref_index, match_if.query_index,
                         match_if.dist_sq);
            end else begin
                want = expected_matches.pop_front();
                check_field("found", want.found, match_if.found);
                check_field("ref_index", want.ref_index, match_if.ref_index);
                check_field("query_index", want.query_index, match_if.query_index);
                check_field("dist_sq", want.dist_sq, match_if.dist_sq);
            end
        end
    end

    task automatic queue_beat(input logic action, input logic start_set, input int x,
                              input int y, input int label);
        t_point_beat b;
        b.action    = action;
        b.start_set = start_set;
        b.x         = COORD_BITS'(x);
        b.y         = COORD_BITS'(y);
        b.label     = LABEL_W'(label);
        pending_beats.insert(pending_beats.size(), b);
        beats_queued++;
    endtask

    function automatic int rand_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // A coordinate close to c, sometimes exactly c, kept inside the Q4.12 range.
    function automatic int near(input int c, input int spread);
        int v;
        v = c;
        if ($urandom_range(0, 7) != 0)
            v = c + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // One frame: a set of reference points, then queries mostly aimed at them.
    task automatic queue_frame(input int spread);
        int px[$];
        int py[$];
        int pl[$];
        int n_pts;
        int n_q;
        int cx;
        int cy;
        int k;
        int x;
        int y;
        int l;
        int pick;
        n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 20);
        n_q   = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 14);
        cx    = rand_coord();
        cy    = rand_coord();
        for (int i = 0; i < n_pts; i++) begin
            pick = $urandom_range(0, 9);
            l    = $urandom_range(0, 3);
            if (i != 0 && pick == 0) begin
                // A repeated point sets up a tie between two indexes.
                k = $urandom_range(0, i - 1);
                x = px[k];
                y = py[k];
                l = pl[k];
            end else if (pick < 5) begin
                x = rand_coord();
                y = rand_coord();
            end else begin
                x = near(cx, 2 * spread);
                y = near(cy, 2 * spread);
            end
            px.insert(px.size(), x);
            py.insert(py.size(), y);
            pl.insert(pl.size(), l);
            // Now and then the set is not restarted and the points append.
            queue_beat(ACT_STORE, i == 0 && $urandom_range(0, 15) != 0, x, y, l);
        end
        for (int i = 0; i < n_q; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                queue_beat(ACT_STORE, $urandom_range(0, 3) == 0, rand_coord(), rand_coord(),
                           $urandom_range(0, 3));
            end else if (pick < 5) begin
                queue_beat(ACT_QUERY, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                           $urandom_range(0, 3));
            end else begin
                k = $urandom_range(0, n_pts - 1);
                l = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : pl[k];
                queue_beat(ACT_QUERY, 1'($urandom_range(0, 1)), near(px[k], spread),
                           near(py[k], spread), l);
            end
        end
    endtask

    task automatic write_gate(input logic [DIST_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gate_now = value;
        gate_settings++;
    endtask

    // Stores give no beat back, so allow a full search time after the last match.
    task automatic wait_drained();
        while (pending_beats.size() != 0 || expected_matches.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [DIST_W-1:0] gate_pick;
        int                spread;
        int                phase_start;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        point_if.valid       = 1'b0;
        point_if.action      = ACT_STORE;
        point_if.start_set   = 1'b0;
        point_if.pos_x       = '0;
        point_if.pos_y       = '0;
        point_if.class_label = '0;
        match_if.ready       = 1'b0;
        set_size             = 0;
        query_count          = '0;
        gate_now             = GATE_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset gate.
        queue_beat(ACT_QUERY, 1'b0, 0, 0, 0);
        queue_beat(ACT_STORE, 1'b1, 32767, 32767, 3);
        queue_beat(ACT_STORE, 1'b0, -32768, -32768, 3);
        queue_beat(ACT_STORE, 1'b0, 0, 0, 0);
        queue_beat(ACT_STORE, 1'b0, 100, 100, 1);
        queue_beat(ACT_STORE, 1'b0, 100, 100, 1);
        queue_beat(ACT_STORE, 1'b0, -100, -100, 2);
        queue_beat(ACT_QUERY, 1'b1, 32767, 32767, 3);
        queue_beat(ACT_QUERY, 1'b0, -32768, -32768, 3);
        queue_beat(ACT_QUERY, 1'b0, 110, 90, 1);
        queue_beat(ACT_QUERY, 1'b0, 0, 0, 1);
        queue_beat(ACT_QUERY, 1'b0, 32767, 32767, 0);
        queue_beat(ACT_QUERY, 1'b0, -32768, 32767, 3);
        queue_beat(ACT_QUERY, 1'b0, 32767, -32768, 3);
        queue_beat(ACT_QUERY, 1'b0, -90, -90, 2);
        // 817^2 + 60^2 equals the reset gate exactly, one step less passes.
        queue_beat(ACT_QUERY, 1'b0, 817, 60, 0);
        queue_beat(ACT_QUERY, 1'b0, 817, 59, 0);
        queue_beat(ACT_QUERY, 1'b0, -817, -59, 0);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            idle_on   = (p != PHASE_COUNT - 1);
            gate_pick = gate_plan[p];
            spread    = spread_plan[p];
            if (p == RANDOM_GATE_PHASE) begin
                gate_pick = $urandom;
                spread    = $urandom_range(16, 30000);
            end
            write_gate(gate_pick);
            phase_start = beats_queued;
            while (beats_queued - phase_start < PHASE_ITEMS)
                queue_frame(spread);
            wait_drained();
        end

        $display("Covered %0d stores (%0d dropped on a full set) and %0d queries, %0d matched.",
                 stores_seen, dropped_stores, queries_seen, hits_seen);
        $display("Query counter wrapped %0d times; gate written %0d times after the reset value.",
                 wraps_seen, gate_settings);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/lnpm_pkg.sv
rtl/lnpm_if.sv
rtl/lnpm_cell.sv
rtl/labeled_nearest_point_matcher_top.sv
bench/labeled_nearest_point_matcher_top_test.sv
